FILE: rtl/mtwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_pkg
// Constants and helper functions shared by the MT19937 word generator.
// ----------------------------------------------------------------------------
package mtwg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;

  localparam logic [31:0] TWIST_MATRIX  = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
  localparam logic [31:0] INIT_MULT     = 32'h6c07_8965;
  localparam logic [31:0] DEFAULT_SEED  = 32'd5489;

  // Item kinds on the input channel
  localparam logic KIND_RESEED = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  // Output tempering: four shift/mask/xor steps
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] t;
    t = w;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_MASK_B);
    t = t ^ ((t << 15) & TEMPER_MASK_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // Twist recurrence on the mixed upper/lower word and the offset word
  function automatic logic [31:0] twist(input logic [31:0] mixed, input logic [31:0] far_word);
    logic [31:0] t;
    t = far_word ^ (mixed >> 1);
    if (mixed[0]) begin
      t = t ^ TWIST_MATRIX;
    end
    return t;
  endfunction

endpackage

FILE: rtl/mtwg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_in_if / mtwg_out_if
// Valid/ready channels for the request and result beats.
// ----------------------------------------------------------------------------
interface mtwg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface mtwg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

FILE: rtl/mtwg_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_store
// State word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtwg_store #(
  parameter int unsigned STATE_WORDS = mtwg_pkg::STATE_WORDS,
  localparam int unsigned AW = $clog2(STATE_WORDS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [31:0]   rd_data_a,
  output logic [31:0]   rd_data_b
);

  logic [31:0] mem [STATE_WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: rtl/mtwg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_core
// Sequencer for seeding, twisting and tempering, with the result register.
// ----------------------------------------------------------------------------
module mtwg_core #(
  parameter int unsigned STATE_WORDS = mtwg_pkg::STATE_WORDS,
  localparam int unsigned AW = $clog2(STATE_WORDS),
  localparam int unsigned PW = $clog2(STATE_WORDS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  mtwg_in_if.sink         in_ch,
  mtwg_out_if.source      out_ch,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [31:0]     wr_data,
  output logic [AW-1:0]   rd_addr_a,
  output logic [AW-1:0]   rd_addr_b,
  input  logic [31:0]     rd_data_a,
  input  logic [31:0]     rd_data_b
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD0,
    ST_RD1,
    ST_TW
  } state_t;

  localparam logic [PW:0]   WORDS_X  = (PW+1)'(STATE_WORDS);
  localparam logic [PW:0]   OFFSET_X = (PW+1)'(mtwg_pkg::TWIST_OFFSET);
  localparam logic [PW-1:0] POS_END  = PW'(STATE_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);

  state_t        state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] next_r, next_nxt;
  logic [AW-1:0] far_r, far_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   mixed_r, mixed_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_word_r, out_word_nxt;

  logic          in_fire;
  logic          out_free;
  logic [AW-1:0] pos_start;
  logic [PW:0]   far_sum;
  logic [31:0]   fill_word;
  logic [31:0]   fresh;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.random_word = out_word_r;
  assign out_free         = !out_valid_r || out_ch.ready;

  // Wrap the read position at the end of a generation
  assign pos_start = (pos_r >= POS_END) ? '0 : pos_r[AW-1:0];
  assign far_sum   = (PW+1)'(pos_start) + OFFSET_X;

  // Seeding step: one multiply and add per word
  assign fill_word = (mtwg_pkg::INIT_MULT * (prev_r ^ (prev_r >> 30))) + 32'(cnt_r);
  assign fresh     = mtwg_pkg::twist(mixed_r, rd_data_a);

  // Next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    far_nxt       = far_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    mixed_nxt     = mixed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = fresh;
    rd_addr_a     = cur_r;
    rd_addr_b     = next_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == mtwg_pkg::KIND_RESEED) begin
            seed_nxt  = in_ch.seed_value;
            cnt_nxt   = '0;
            state_nxt = ST_FILL;
          end else begin
            cur_nxt   = pos_start;
            next_nxt  = (pos_start == LAST_IDX) ? '0 : pos_start + AW'(1);
            far_nxt   = (far_sum >= WORDS_X) ? AW'(far_sum - WORDS_X) : AW'(far_sum);
            state_nxt = ST_RD0;
          end
        end
      end
      ST_FILL: begin
        wr_en    = 1'b1;
        wr_addr  = cnt_r;
        wr_data  = (cnt_r == '0) ? seed_r : fill_word;
        prev_nxt = wr_data;
        if (cnt_r == LAST_IDX) begin
          pos_nxt   = POS_END;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_RD0: begin
        // fetch the current and neighbor words
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        mixed_nxt = {rd_data_a[31], rd_data_b[30:0]};
        rd_addr_a = far_r;
        state_nxt = ST_TW;
      end
      ST_TW: begin
        // hold the offset word read until the result register is free
        rd_addr_a = far_r;
        if (out_free) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtwg_pkg::temper(fresh);
          pos_nxt       = PW'(cur_r) + PW'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      seed_r      <= mtwg_pkg::DEFAULT_SEED;
      pos_r       <= POS_END;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seed_r      <= seed_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    next_r     <= next_nxt;
    far_r      <= far_nxt;
    prev_r     <= prev_nxt;
    mixed_r    <= mixed_nxt;
    out_word_r <= out_word_nxt;
  end

  // Read position never runs past the end of a generation
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_END)
    else $error("read position out of range");

  // A completed fill leaves a new generation due
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && cnt_r == LAST_IDX) |=> (pos_r == POS_END))
    else $error("fill did not mark a generation due");

  // A new result beat comes only out of the twist step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_TW))
    else $error("result beat without a twist");

  // Neither the offset word nor the neighbor word is the word being rewritten
  a_far_ne: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TW) |-> (far_r != cur_r && next_r != cur_r))
    else $error("twist operands alias the written word");

  // No request beat is taken while seeding
  a_no_take_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !in_ch.ready)
    else $error("request taken during fill");

endmodule

FILE: rtl/mt19937_word_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_generator_top
// MT19937 32-bit generator: state words in memory, one word twisted per draw.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload             | notes
//  in_ch   | in  | kind, seed_value         | kind 0 reseeds, kind 1 draws
//  out_ch  | out | random_word              | one beat per draw
//
//  A draw steps through accept, two memory reads (current and
//  neighbor word, then offset word), then twist, write back and temper.
//  A reseed accepts the request, then does one multiply-add and memory write
//  per word for 624 words.
//  After reset the store is filled for seed 5489, and no request is taken.
//  A held result beat does not block a new request; the twist step waits only
//  when the result register is still full.
// ----------------------------------------------------------------------------
module mt19937_word_generator_top #(
  parameter int unsigned STATE_WORDS = mtwg_pkg::STATE_WORDS
) (
  input  logic       clk,
  input  logic       rst_n,
  mtwg_in_if.sink    in_ch,
  mtwg_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(STATE_WORDS);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [31:0]   rd_data_a;
  logic [31:0]   rd_data_b;

  // Sequencer
  mtwg_core #(
    .STATE_WORDS (STATE_WORDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // State word memory
  mtwg_store #(
    .STATE_WORDS (STATE_WORDS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule
